@@ design/snrr_pkg.sv @@
// ---------------------------------------------------------------------------
// snrr_pkg
// Shared types, constants and helpers of the light-sensor read responder.
// ---------------------------------------------------------------------------
package snrr_pkg;

	// Frame bytes
	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] OP_READ = 8'h01;
	localparam logic [7:0] ACK_GOOD = 8'h00;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// Register reset values
	localparam logic [15:0] NET_ID_RESET = 16'hC0C2;
	localparam logic [7:0] NODE_ADDR_RESET = 8'd2;

	// Lux scaling: lux = floor(adc * 3300 / 4095 / 4), clamped
	localparam logic [9:0] LUX_RESET = 10'd200;
	localparam logic [9:0] LUX_MIN = 10'd10;
	localparam logic [9:0] LUX_MAX = 10'd999;
	localparam logic [11:0] MV_SCALE = 12'd3300;
	// ceil(2^36 / 4095); exact floor for products below 2^24
	localparam logic [24:0] RECIP_4095 = 25'd16781314;

	// Reply queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Byte positions within the reply frame
	localparam logic [4:0] POS_HDR = 5'd0;
	localparam logic [4:0] POS_CMD = 5'd1;
	localparam logic [4:0] POS_NETH = 5'd2;
	localparam logic [4:0] POS_NETL = 5'd3;
	localparam logic [4:0] POS_ADDR = 5'd4;
	localparam logic [4:0] POS_ACK = 5'd5;
	localparam logic [4:0] POS_LEN = 5'd6;
	localparam logic [4:0] POS_TEXT = 5'd7;
	localparam logic [4:0] POS_TEXT_END = 5'd12;
	localparam logic [4:0] POS_DIGIT = 5'd13;
	// Length byte and last position for two- and three-digit text
	localparam logic [7:0] LEN_2DIG = 8'd12;
	localparam logic [7:0] LEN_3DIG = 8'd13;
	localparam logic [4:0] LAST_2DIG = 5'd18;
	localparam logic [4:0] LAST_3DIG = 5'd19;

	typedef enum logic {
		CFG_NETWORK_ID   = 1'b0,
		CFG_NODE_ADDRESS = 1'b1
	} cfg_index_t;

	// One queued reply: decimal digits of the lux snapshot plus identity
	typedef struct packed {
		logic        three;
		logic [3:0]  hund;
		logic [3:0]  tens;
		logic [3:0]  ones;
		logic [15:0] net_id;
		logic [7:0]  addr;
	} reply_t;

	// Split lux (10..999) into decimal digits by reciprocal multiplies
	function automatic logic [11:0] lux_digits(logic [9:0] lux);
		logic [15:0] hp;
		logic [3:0]  h;
		logic [9:0]  hx;
		logic [6:0]  rem;
		logic [14:0] tp;
		logic [3:0]  t;
		logic [3:0]  o;
		hp = {6'd0, lux} * 16'd41;
		h = hp[15:12];
		hx = {6'd0, h} * 10'd100;
		rem = 7'(lux - hx);
		tp = {8'd0, rem} * 15'd205;
		t = tp[14:11];
		o = 4'(rem - {3'd0, t} * 7'd10);
		return {h, t, o};
	endfunction

	// "Light:"
	function automatic logic [7:0] prefix_char(logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h4C;
			3'd1: c = 8'h69;
			3'd2: c = 8'h67;
			3'd3: c = 8'h68;
			3'd4: c = 8'h74;
			default: c = 8'h3A;
		endcase
		return c;
	endfunction

	// "Lux"
	function automatic logic [7:0] suffix_char(logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h4C;
			2'd1: c = 8'h75;
			default: c = 8'h78;
		endcase
		return c;
	endfunction

endpackage

@@ design/sensor_node_read_responder.sv @@
// ---------------------------------------------------------------------------
// sensor_node_read_responder
// Light-sensor node responder: parses read requests, answers with a lux frame.
// ---------------------------------------------------------------------------
// The input channel takes one item per cycle: a packet byte (func 0) or an
// ADC sample (func 1). Each item passes a two-stage pipeline, the depth of
// the lux multiply chain (adc*3300, then a reciprocal of 4095), so a sample
// affects every reply requested after it. A valid request (header 0x55,
// command 1, checksum, network id and node address all matching) queues a
// reply descriptor in a four-entry queue; the serializer then sends the
// 19- or 20-byte frame at one byte per cycle unless the output stalls, and
// idles between frames. The input stalls only while the queue is full and
// the reply at the pipeline tail waits to enter it. Configuration writes
// are always ready and take effect on the next cycle.
module sensor_node_read_responder (
	input  logic        clk,
	input  logic        arst_n,
	// item input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	input  logic [11:0] adc_sample,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// response bytes
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        tx_last
);

	snrr_pkg::reply_t push_entry, pop_entry;
	logic             push, pop, q_full, q_empty;

	// Parse, scale lux, classify requests
	snrr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.rx_byte    (rx_byte),
		.rx_last    (rx_last),
		.adc_sample (adc_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Decouple the parser from the transmitter
	snrr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	// Expand each descriptor into the response frame
	snrr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.empty     (q_empty),
		.head      (pop_entry),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tx_byte   (tx_byte),
		.tx_last   (tx_last)
	);

endmodule

@@ design/snrr_front.sv @@
// ---------------------------------------------------------------------------
// snrr_front
// Request parser, config registers and two-stage lux pipeline; pushes
// reply descriptors into the queue in item order.
// ---------------------------------------------------------------------------
module snrr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [7:0]          rx_byte,
	input  logic                rx_last,
	input  logic [11:0]         adc_sample,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                push,
	output snrr_pkg::reply_t    push_entry,
	input  logic                q_full
);

	typedef enum logic [6:0] {
		PH_HUNT = 7'b0000001,
		PH_CMD  = 7'b0000010,
		PH_NETH = 7'b0000100,
		PH_NETL = 7'b0001000,
		PH_ADDR = 7'b0010000,
		PH_SUM  = 7'b0100000,
		PH_DONE = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  sum_q, sum_d;
	logic        match_q, match_d;
	logic [7:0]  expect_c;
	logic        reply_now;
	logic [15:0] net_id_q;
	logic [7:0]  addr_q;
	logic [9:0]  light_q;
	logic        adv, acc;

	logic        valid_s1, adc_s1, reply_s1;
	logic [23:0] x_s1;
	logic        valid_s2, adc_s2, reply_s2;
	logic [47:0] prod_s2;
	logic [9:0]  lux_raw, lux_new;
	logic        retire;
	logic [11:0] dig;

	// Hold the whole pipeline while a reply cannot enter the queue
	assign adv = !(valid_s2 && reply_s2 && q_full);
	assign in_stall = !adv;
	assign acc = in_valid && adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_id_q <= snrr_pkg::NET_ID_RESET;
			addr_q <= snrr_pkg::NODE_ADDR_RESET;
		end else if (cfg_valid) begin
			unique case (snrr_pkg::cfg_index_t'(cfg_index))
				snrr_pkg::CFG_NETWORK_ID: net_id_q <= cfg_data;
				snrr_pkg::CFG_NODE_ADDRESS: addr_q <= cfg_data[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_CMD: expect_c = snrr_pkg::OP_READ;
			PH_NETH: expect_c = net_id_q[15:8];
			PH_NETL: expect_c = net_id_q[7:0];
			PH_ADDR: expect_c = addr_q;
			default: expect_c = sum_q;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		sum_d = sum_q;
		match_d = match_q;
		reply_now = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == snrr_pkg::HDR_BYTE) begin
					phase_d = PH_CMD;
					sum_d = rx_byte;
					match_d = 1'b1;
				end
			end
			PH_CMD, PH_NETH, PH_NETL, PH_ADDR: begin
				if (rx_byte != expect_c)
					match_d = 1'b0;
				sum_d = sum_q + rx_byte;
				unique case (phase_q)
					PH_CMD: phase_d = PH_NETH;
					PH_NETH: phase_d = PH_NETL;
					PH_NETL: phase_d = PH_ADDR;
					default: phase_d = PH_SUM;
				endcase
			end
			PH_SUM: begin
				phase_d = PH_DONE;
				reply_now = !func && match_q && (rx_byte == expect_c);
			end
			default: begin
			end
		endcase
		if (rx_last) begin
			phase_d = PH_HUNT;
			sum_d = 8'd0;
			match_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			sum_q <= 8'd0;
			match_q <= 1'b1;
		end else if (acc && !func) begin
			phase_q <= phase_d;
			sum_q <= sum_d;
			match_q <= match_d;
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Pipeline payload: adc*3300, then reciprocal of 4095
	always_ff @(posedge clk) begin
		if (adv) begin
			adc_s1 <= func;
			reply_s1 <= reply_now;
			x_s1 <= 24'({12'd0, adc_sample} * {12'd0, snrr_pkg::MV_SCALE});
			adc_s2 <= adc_s1;
			reply_s2 <= reply_s1;
			prod_s2 <= 48'({25'd0, x_s1} * {24'd0, snrr_pkg::RECIP_4095});
		end
	end

	assign lux_raw = prod_s2[47:38];
	always_comb begin
		if (lux_raw < snrr_pkg::LUX_MIN)
			lux_new = snrr_pkg::LUX_MIN;
		else if (lux_raw > snrr_pkg::LUX_MAX)
			lux_new = snrr_pkg::LUX_MAX;
		else
			lux_new = lux_raw;
	end

	assign retire = valid_s2 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			light_q <= snrr_pkg::LUX_RESET;
		else if (retire && adc_s2)
			light_q <= lux_new;
	end

	assign dig = snrr_pkg::lux_digits(light_q);
	assign push = retire && reply_s2;
	assign push_entry.three = (dig[11:8] != 4'd0);
	assign push_entry.hund = dig[11:8];
	assign push_entry.tens = dig[7:4];
	assign push_entry.ones = dig[3:0];
	assign push_entry.net_id = net_id_q;
	assign push_entry.addr = addr_q;

endmodule

@@ design/snrr_queue.sv @@
// ---------------------------------------------------------------------------
// snrr_queue
// Small register FIFO of reply descriptors between parser and serializer.
// ---------------------------------------------------------------------------
module snrr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  snrr_pkg::reply_t push_entry,
	output logic             full,
	input  logic             pop,
	output snrr_pkg::reply_t pop_entry,
	output logic             empty
);

	snrr_pkg::reply_t                 mem_q [snrr_pkg::Q_DEPTH];
	logic [snrr_pkg::Q_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [snrr_pkg::Q_CNT_W-1:0]     cnt_q;

	assign full = (cnt_q == snrr_pkg::Q_CNT_W'(snrr_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("reply queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("reply queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("reply queue count did not advance on push");

endmodule

@@ design/snrr_back.sv @@
// ---------------------------------------------------------------------------
// snrr_back
// Reply serializer: expands one descriptor into the response frame, one
// byte per cycle into the output register unless stalled; running checksum.
// ---------------------------------------------------------------------------
module snrr_back (
	input  logic             clk,
	input  logic             arst_n,
	output logic             pop,
	input  logic             empty,
	input  snrr_pkg::reply_t head,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       tx_byte,
	output logic             tx_last
);

	snrr_pkg::reply_t cur_q;
	logic             busy_q;
	logic [4:0]       k_q;
	logic [7:0]       chk_q;
	logic             out_valid_q;
	logic [7:0]       tx_byte_q;
	logic             tx_last_q;

	logic             out_free;
	logic [4:0]       nd, p, d, last_idx;
	logic             is_last;
	logic [3:0]       digit;
	logic [7:0]       byte_c;

	assign pop = !busy_q && !empty;
	assign out_free = !out_valid_q || !out_stall;

	assign nd = cur_q.three ? 5'd3 : 5'd2;
	assign p = k_q - snrr_pkg::POS_DIGIT;
	assign d = cur_q.three ? p : p + 5'd1;
	assign last_idx = cur_q.three ? snrr_pkg::LAST_3DIG : snrr_pkg::LAST_2DIG;
	assign is_last = (k_q == last_idx);

	always_comb begin
		case (d[1:0])
			2'd0: digit = cur_q.hund;
			2'd1: digit = cur_q.tens;
			default: digit = cur_q.ones;
		endcase
	end

	always_comb begin
		case (k_q) inside
			snrr_pkg::POS_HDR: byte_c = snrr_pkg::HDR_BYTE;
			snrr_pkg::POS_CMD: byte_c = snrr_pkg::OP_READ;
			snrr_pkg::POS_NETH: byte_c = cur_q.net_id[15:8];
			snrr_pkg::POS_NETL: byte_c = cur_q.net_id[7:0];
			snrr_pkg::POS_ADDR: byte_c = cur_q.addr;
			snrr_pkg::POS_ACK: byte_c = snrr_pkg::ACK_GOOD;
			snrr_pkg::POS_LEN:
				byte_c = cur_q.three ? snrr_pkg::LEN_3DIG : snrr_pkg::LEN_2DIG;
			[snrr_pkg::POS_TEXT:snrr_pkg::POS_TEXT_END]:
				byte_c = snrr_pkg::prefix_char(3'(k_q - snrr_pkg::POS_TEXT));
			default: begin
				if (is_last)
					byte_c = chk_q;
				else if (p < nd)
					byte_c = snrr_pkg::ASCII_ZERO + {4'd0, digit};
				else
					byte_c = snrr_pkg::suffix_char(2'(p - nd));
			end
		endcase
	end

	// Take the head descriptor when a new frame starts
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			chk_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q <= '0;
				chk_q <= '0;
			end
			if (busy_q && out_free) begin
				out_valid_q <= 1'b1;
				chk_q <= chk_q + byte_c;
				k_q <= k_q + 5'd1;
				if (is_last)
					busy_q <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && out_free) begin
			tx_byte_q <= byte_c;
			tx_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_byte = tx_byte_q;
	assign tx_last = tx_last_q;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: light-sensor read responder
// Drives packet bytes and ADC samples into the responder and writes its two
// registers between phases. A cycle-free predictor builds every reply frame,
// and each transmitted byte is checked against it in order. The run covers
// directed request cases, a random mix with idling on both sides, a long
// receiver hold-off that fills the reply queue, and a closing stretch without
// gaps.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 8;     // pipeline drain plus slack
	localparam int HOLD_CYCLES   = 300;   // receiver hold-off in the pressure test
	localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
	localparam int RANDOM_ITEMS  = 16;
	localparam int REG_EVERY     = 8;     // random items between register rewrites
	localparam int REPORT_MAX    = 10;

	// Parser position inside a request, one step per byte after the header
	typedef enum int {
		ST_HUNT, ST_CMD, ST_NETH, ST_NETL, ST_ADDR, ST_SUM, ST_DONE
	} req_stage_t;

	// Ways to spoil a request
	typedef enum int {
		FLAW_NONE, FLAW_CMD, FLAW_NETH, FLAW_NETL, FLAW_ADDR, FLAW_SUM, FLAW_SHORT
	} flaw_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} tx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        rx_last = 1'b0;
	logic [11:0] adc_sample = 12'h000;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  tx_byte;
	logic        tx_last;

	// Predictor state: registers, parser and current lux
	logic [15:0] net_id_now;
	logic [7:0]  addr_now;
	logic [9:0]  lux_now;
	req_stage_t  req_stage;
	logic [7:0]  req_sum;
	logic        req_ok;

	tx_item_t    reply_q[$];          // response bytes still owed by the block
	int          mismatch_count = 0;
	int          quiet_cycles = 0;
	int          counted = 0;         // request bytes and ADC samples sent so far

	// Idling controls for the sender and the receiver
	logic        idling_on = 1'b1;
	logic        mix_adc = 1'b0;      // slip ADC samples between request bytes
	logic        hold_req = 1'b0;
	int          hold_left = 0;
	int          stall_left = 0;

	sensor_node_read_responder u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.rx_byte    (rx_byte),
		.rx_last    (rx_last),
		.adc_sample (adc_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_byte    (tx_byte),
		.tx_last    (tx_last)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_request();
		req_stage = ST_HUNT;
		req_sum = 8'h00;
		req_ok = 1'b1;
	endfunction

	// Append the full reply frame: identity, ack, length, text, checksum
	function automatic void queue_reply();
		logic [7:0] frame[$];
		logic [7:0] chk;
		string      txt;
		txt = $sformatf("Light:%0dLux", lux_now);
		frame = '{snrr_pkg::HDR_BYTE, snrr_pkg::OP_READ, net_id_now[15:8],
			net_id_now[7:0], addr_now, snrr_pkg::ACK_GOOD, 8'(txt.len() + 1)};
		for (int i = 0; i < txt.len(); i++)
			frame.push_back(txt[i]);
		chk = 8'h00;
		foreach (frame[i]) begin
			reply_q.push_back('{data: frame[i], last: 1'b0});
			chk += frame[i];
		end
		reply_q.push_back('{data: chk, last: 1'b1});
	endfunction

	// Advance the predictor by one accepted item
	function automatic void predict_item(logic f, logic [7:0] b, logic l, logic [11:0] adc);
		logic [7:0] want;
		int         lux;
		if (f) begin
			// ADC sample: rescale to lux, parser untouched
			lux = (int'(adc) * 3300 / 4095) / 4;
			if (lux > int'(snrr_pkg::LUX_MAX))
				lux = int'(snrr_pkg::LUX_MAX);
			if (lux < int'(snrr_pkg::LUX_MIN))
				lux = int'(snrr_pkg::LUX_MIN);
			lux_now = 10'(lux);
			return;
		end
		case (req_stage)
			ST_HUNT: begin
				if (b == snrr_pkg::HDR_BYTE) begin
					req_stage = ST_CMD;
					req_sum = b;
					req_ok = 1'b1;
				end
			end
			ST_DONE: ;
			default: begin
				case (req_stage)
					ST_CMD:  want = snrr_pkg::OP_READ;
					ST_NETH: want = net_id_now[15:8];
					ST_NETL: want = net_id_now[7:0];
					ST_ADDR: want = addr_now;
					default: want = req_sum;
				endcase
				if (b != want)
					req_ok = 1'b0;
				if (req_stage != ST_SUM) begin
					req_sum += b;
					req_stage = req_stage_t'(req_stage + 1);
				end else begin
					req_stage = ST_DONE;
					if (req_ok)
						queue_reply();
				end
			end
		endcase
		if (l)
			clear_request();
	endfunction

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Offer one item and hold it until accepted. Called at a rising edge;
	// leaves valid high so back-to-back items need no extra edge.
	task automatic push_item(logic f, logic [7:0] b, logic l, logic [11:0] adc);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		rx_byte    <= b;
		rx_last    <= l;
		adc_sample <= adc;
		do @(posedge clk); while (in_stall);
		predict_item(f, b, l, adc);
	endtask

	// Packet byte with a random, ignored sample field
	task automatic send_byte(logic [7:0] b, logic l);
		push_item(1'b0, b, l, 12'($urandom));
	endtask

	// ADC sample with random, ignored byte fields
	task automatic send_adc(logic [11:0] adc);
		push_item(1'b1, 8'($urandom), 1'($urandom), adc);
	endtask

	function automatic logic [7:0] flip_mask();
		return 8'($urandom_range(1, 255));
	endfunction

	// Send one request packet. Noise bytes (never a header) lead, tail bytes
	// trail the sum byte and start with a second header that must be ignored.
	task automatic send_request(flaw_t flaw, int noise, int tail);
		logic [7:0] req[6];
		logic [7:0] b;
		int         len;
		req[0] = snrr_pkg::HDR_BYTE;
		req[1] = snrr_pkg::OP_READ;
		req[2] = net_id_now[15:8];
		req[3] = net_id_now[7:0];
		req[4] = addr_now;
		case (flaw)
			FLAW_CMD:  req[1] ^= flip_mask();
			FLAW_NETH: req[2] ^= flip_mask();
			FLAW_NETL: req[3] ^= flip_mask();
			FLAW_ADDR: req[4] ^= flip_mask();
			default: ;
		endcase
		req[5] = req[0] + req[1] + req[2] + req[3] + req[4];
		if (flaw == FLAW_SUM)
			req[5] ^= flip_mask();
		len = (flaw == FLAW_SHORT) ? $urandom_range(1, 5) : 6;
		// close any packet left open so the header is seen
		if (req_stage != ST_HUNT)
			send_byte(8'($urandom), 1'b1);
		repeat (noise) begin
			b = 8'($urandom);
			send_byte((b == snrr_pkg::HDR_BYTE) ? ~b : b, 1'b0);
		end
		for (int i = 0; i < len; i++) begin
			if (mix_adc && $urandom_range(0, 7) == 0) begin
				send_adc(12'($urandom));
				counted++;
			end
			send_byte(req[i], (i == len - 1) && (flaw == FLAW_SHORT || tail == 0));
		end
		if (flaw != FLAW_SHORT)
			for (int t = 0; t < tail; t++)
				send_byte((t == 0) ? snrr_pkg::HDR_BYTE : 8'($urandom), t == tail - 1);
		counted += len;
	endtask

	// Drop valid, wait for every owed byte, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (reply_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, only ever issued with the block idle
	task automatic write_reg(snrr_pkg::cfg_index_t idx, logic [15:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			snrr_pkg::CFG_NETWORK_ID:   net_id_now = data;
			snrr_pkg::CFG_NODE_ADDRESS: addr_now = data[7:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Output side: stall driver and byte checker
	// ------------------------------------------------------------------

	// Random stall bursts, or one long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each transmitted byte with the oldest owed byte
	always @(posedge clk) begin
		tx_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected tx item: byte %02h last %0b", tx_byte, tx_last);
			end else begin
				want = reply_q.pop_front();
				if (tx_byte !== want.data || tx_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("tx item mismatch: expected %02h/%0b, got %02h/%0b",
							want.data, want.last, tx_byte, tx_last);
				end
			end
		end
	end

	// Count cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// A matching request under reset registers, sum byte marked last
	task automatic test_reset_registers();
		send_request(FLAW_NONE, 2, 0);
	endtask

	// Lux clamp at the low end, full scale, and the two/three digit border
	task automatic test_lux_extremes();
		send_adc(12'h000);
		send_request(FLAW_NONE, 0, 0);
		send_adc(12'hFFF);
		send_request(FLAW_NONE, 0, 0);
		send_adc(12'd496);
		send_request(FLAW_NONE, 0, 0);
		send_adc(12'd497);
		send_request(FLAW_NONE, 0, 2);
	endtask

	// Every way a request can fail, a repeated header after a good one,
	// and header-valued bytes inside the request
	task automatic test_request_flaws();
		send_request(FLAW_SHORT, 0, 0);
		send_request(FLAW_CMD, 0, 0);
		send_request(FLAW_NETH, 0, 0);
		send_request(FLAW_NETL, 0, 0);
		send_request(FLAW_ADDR, 0, 0);
		send_request(FLAW_SUM, 0, 0);
		send_request(FLAW_NONE, 1, 3);
		write_reg(snrr_pkg::CFG_NETWORK_ID, {snrr_pkg::HDR_BYTE, snrr_pkg::HDR_BYTE});
		write_reg(snrr_pkg::CFG_NODE_ADDRESS, {8'h00, snrr_pkg::HDR_BYTE});
		send_request(FLAW_NONE, 0, 0);
	endtask

	// Register extremes and a random setting, one request each
	task automatic test_register_sweep();
		write_reg(snrr_pkg::CFG_NETWORK_ID, 16'h0000);
		write_reg(snrr_pkg::CFG_NODE_ADDRESS, 16'h0000);
		send_request(FLAW_NONE, 0, 0);
		write_reg(snrr_pkg::CFG_NETWORK_ID, 16'hFFFF);
		write_reg(snrr_pkg::CFG_NODE_ADDRESS, 16'hFFFF);
		send_request(FLAW_NONE, 0, 1);
		write_reg(snrr_pkg::CFG_NETWORK_ID, 16'($urandom));
		write_reg(snrr_pkg::CFG_NODE_ADDRESS, 16'($urandom));
		send_request(FLAW_NONE, 0, 0);
	endtask

	// Change both registers while a request is half parsed; each byte is
	// judged by the value in force when it arrives
	task automatic test_mid_request_write();
		if (req_stage != ST_HUNT)
			send_byte(8'($urandom), 1'b1);
		send_byte(snrr_pkg::HDR_BYTE, 1'b0);
		send_byte(snrr_pkg::OP_READ, 1'b0);
		send_byte(net_id_now[15:8], 1'b0);
		write_reg(snrr_pkg::CFG_NETWORK_ID, {net_id_now[15:8], 8'($urandom)});
		write_reg(snrr_pkg::CFG_NODE_ADDRESS, 16'($urandom));
		send_byte(net_id_now[7:0], 1'b0);
		send_byte(addr_now, 1'b0);
		send_byte(snrr_pkg::HDR_BYTE + snrr_pkg::OP_READ + net_id_now[15:8]
			+ net_id_now[7:0] + addr_now, 1'b1);
	endtask

	// Mostly well-formed requests with random content, some spoiled,
	// plus samples and line noise; registers reshuffled now and then
	// while idling is allowed
	task automatic random_traffic(int budget);
		int    start;
		int    next_reg;
		int    pick;
		flaw_t flaw;
		start = counted;
		next_reg = counted + REG_EVERY;
		mix_adc = 1'b1;
		while (counted - start < budget) begin
			pick = $urandom_range(0, 19);
			if (pick < 11) begin
				flaw = ($urandom_range(0, 3) == 0) ?
					flaw_t'($urandom_range(FLAW_CMD, FLAW_SHORT)) : FLAW_NONE;
				send_request(flaw, $urandom_range(0, 2), $urandom_range(0, 2));
			end else if (pick < 15) begin
				send_adc(12'($urandom));
				counted++;
			end else begin
				send_byte(8'($urandom), 1'($urandom));
			end
			if (idling_on && counted >= next_reg) begin
				next_reg = counted + REG_EVERY;
				write_reg(snrr_pkg::cfg_index_t'($urandom_range(0, 1)), 16'($urandom));
			end
		end
		mix_adc = 1'b0;
	endtask

	task automatic test_random();
		random_traffic(RANDOM_ITEMS);
	endtask

	// Hold the receiver off while requests keep coming, so the reply
	// queue fills and the input stalls
	task automatic test_backpressure();
		settle();
		idling_on = 1'b0;
		hold_req = 1'b1;
		repeat (7) send_request(FLAW_NONE, 0, 0);
		idling_on = 1'b1;
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_steady_stream();
		settle();
		idling_on = 1'b0;
		random_traffic(10);
	endtask

	initial begin
		net_id_now = snrr_pkg::NET_ID_RESET;
		addr_now = snrr_pkg::NODE_ADDR_RESET;
		lux_now = snrr_pkg::LUX_RESET;
		clear_request();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_registers();
		test_lux_extremes();
		test_request_flaws();
		test_register_sweep();
		test_mid_request_write();
		test_random();
		test_backpressure();
		test_steady_stream();

		settle();
		if (mismatch_count == 0 && reply_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ sensor_node_read_responder.f @@
design/snrr_pkg.sv
design/snrr_front.sv
design/snrr_queue.sv
design/snrr_back.sv
design/sensor_node_read_responder.sv
tb/tb.sv
